// ===== sv/ialu_pkg.sv =====
// Package for the integer ALU with power.
// Holds the data width, the operation codes, the sequencer states and the stream widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ialu_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int OP_WIDTH    = 3;
    localparam int CNT_WIDTH   = $clog2(DATA_WIDTH + 1);
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_SUB = 3'd0,
        OP_ADD = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5,
        OP_NEG = 3'd6
    } t_opcode;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL     = 7'b0000010,
        S_DIV     = 7'b0000100,
        S_DIV_FIX = 7'b0001000,
        S_POW_MUL = 7'b0010000,
        S_POW_SQ  = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== sv/integer_alu_with_power_core.sv =====
// Top level of the signed integer ALU with power.
// One shared multiplier plus a one-bit-per-cycle restoring divider, under a sequencer.
// Depends on ialu_pkg.
//
// Usage:
//   Input stream (s_axis): one item per operation. tuser carries the opcode,
//   tdata carries lhs (low half) and rhs (high half).
//   Output stream (m_axis): one item per input item. tdata carries the
//   wrapped result, tuser the divide-by-zero flag.
//   The block takes one item at a time; s_axis_tready is high only while idle.
//   States an item passes through from accept to the output register:
//     sub, add, negate, unused opcode, divide by zero, negative exponent: S_DONE
//     mul: S_MUL, S_DONE
//     div, mod: S_DIV (one quotient bit per cycle in the divider), S_DIV_FIX, S_DONE
//     pow: S_POW_MUL and S_POW_SQ in turn, then S_POW_MUL once more and S_DONE;
//       each exponent bit costs one multiply and one square on the shared multiplier.
//   The next item is accepted the cycle after the result moves to the output
//   register, so it may overlap a result still waiting to be taken.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees up; no item is lost.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   m_axis_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module integer_alu_with_power_core
    import ialu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // lhs, rhs
    input  wire logic [OP_WIDTH-1:0]    s_axis_tuser,   // opcode
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // result
    output logic                        m_axis_tuser    // div_by_zero
);

    localparam int W = DATA_WIDTH;

    t_state               r_state, n_state;
    t_opcode              r_op, n_op;
    logic [W-1:0]         r_a, n_a;
    logic [W-1:0]         r_b, n_b;
    logic [W-1:0]         r_acc, n_acc;
    logic [W-1:0]         r_sq, n_sq;
    logic [W-1:0]         r_exp, n_exp;
    logic [W-1:0]         r_quo, n_quo;
    logic [W-1:0]         r_rem, n_rem;
    logic [W-1:0]         r_dvs, n_dvs;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [W-1:0]         r_res, n_res;
    logic                 r_dbz, n_dbz;
    logic                 r_m_valid, n_m_valid;
    logic [W-1:0]         r_m_data, n_m_data;
    logic                 r_m_dbz, n_m_dbz;

    logic                 in_accept;
    t_opcode              in_op;
    logic [W-1:0]         in_lhs, in_rhs;
    logic [W-1:0]         mag_a, mag_b;
    logic [W-1:0]         mul_x, mul_y, mul_p;
    logic [W:0]           div_shift, div_diff;
    logic                 div_ge;
    logic                 out_free;

    assign in_lhs = s_axis_tdata[W-1:0];
    assign in_rhs = s_axis_tdata[2*W-1:W];
    assign in_op  = t_opcode'(s_axis_tuser);

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_m_data);
    assign m_axis_tuser  = r_m_dbz;

    assign mag_a = in_lhs[W-1] ? (~in_lhs + W'(1)) : in_lhs;
    assign mag_b = in_rhs[W-1] ? (~in_rhs + W'(1)) : in_rhs;

    // shared multiplier, low W bits of the product
    always_comb begin
        unique case (r_state)
            S_POW_MUL: begin
                mul_x = r_acc;
                mul_y = r_sq;
            end
            S_POW_SQ: begin
                mul_x = r_sq;
                mul_y = r_sq;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_b;
            end
        endcase
    end
    assign mul_p = mul_x * mul_y;

    // restoring divider step on magnitudes
    assign div_shift = {r_rem, r_quo[W-1]};
    assign div_diff  = div_shift - {1'b0, r_dvs};
    assign div_ge    = (div_shift >= {1'b0, r_dvs});

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_exp     = r_exp;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_dbz     = r_dbz;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_dbz   = r_m_dbz;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op  = in_op;
                    n_a   = in_lhs;
                    n_b   = in_rhs;
                    n_dbz = 1'b0;
                    n_res = '0;
                    n_state = S_DONE;
                    unique case (in_op)
                        OP_SUB: n_res = in_lhs - in_rhs;
                        OP_ADD: n_res = in_lhs + in_rhs;
                        OP_NEG: n_res = W'(0) - in_lhs;
                        OP_MUL: n_state = S_MUL;
                        OP_DIV, OP_MOD: begin
                            if (in_rhs == '0) begin
                                n_dbz = 1'b1;
                            end else begin
                                n_quo   = mag_a;
                                n_rem   = '0;
                                n_dvs   = mag_b;
                                n_cnt   = CNT_WIDTH'(W);
                                n_state = S_DIV;
                            end
                        end
                        OP_POW: begin
                            if (in_rhs[W-1]) begin
                                n_res = in_lhs;
                            end else begin
                                n_acc   = W'(1);
                                n_sq    = in_lhs;
                                n_exp   = in_rhs;
                                n_state = S_POW_MUL;
                            end
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            S_MUL: begin
                n_res   = mul_p;
                n_state = S_DONE;
            end
            S_DIV: begin
                n_quo = {r_quo[W-2:0], div_ge};
                n_rem = div_ge ? div_diff[W-1:0] : div_shift[W-1:0];
                n_cnt = r_cnt - CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(1)) begin
                    n_state = S_DIV_FIX;
                end
            end
            S_DIV_FIX: begin
                if (r_op == OP_DIV) begin
                    n_res = (r_a[W-1] ^ r_b[W-1]) ? (W'(0) - r_quo) : r_quo;
                end else begin
                    n_res = r_a[W-1] ? (W'(0) - r_rem) : r_rem;
                end
                n_state = S_DONE;
            end
            S_POW_MUL: begin
                if (r_exp == '0) begin
                    n_res   = r_acc;
                    n_state = S_DONE;
                end else begin
                    if (r_exp[0]) begin
                        n_acc = mul_p;
                    end
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                n_sq    = mul_p;
                n_exp   = r_exp >> 1;
                n_state = S_POW_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_m_dbz   = r_dbz;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_exp    <= n_exp;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_dbz    <= n_dbz;
        r_m_data <= n_m_data;
        r_m_dbz  <= n_m_dbz;
    end

endmodule

`default_nettype wire
